FILE: rtl/keyframe_motion_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Keyframe motion sequencer assertion macros
// Concurrent assertion wrappers. In synthesis they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_MOTION_SEQUENCER_MACROS_SVH
`define KEYFRAME_MOTION_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define KMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define KMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/kms_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe motion sequencer package
// Field widths, command and status codes, register map and shared types.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int unsigned KMS_MAX_FRAMES = 32;
  localparam int unsigned KMS_AXES       = 2;

  localparam int unsigned FUNC_W   = 4;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned SETTLE_W = 10;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [FUNC_W-1:0] FN_TICK        = 4'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND      = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT      = 4'd2;
  localparam logic [FUNC_W-1:0] FN_REPLACE     = 4'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE      = 4'd4;
  localparam logic [FUNC_W-1:0] FN_REMOVE_LAST = 4'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR       = 4'd6;
  localparam logic [FUNC_W-1:0] FN_PLAY        = 4'd7;
  localparam logic [FUNC_W-1:0] FN_PAUSE       = 4'd8;
  localparam logic [FUNC_W-1:0] FN_TOGGLE      = 4'd9;
  localparam logic [FUNC_W-1:0] FN_STOP        = 4'd10;
  localparam logic [FUNC_W-1:0] FN_RESTART     = 4'd11;
  localparam logic [FUNC_W-1:0] FN_GOTO        = 4'd12;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ESTOP     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOVING  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOLDING = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd3;

  localparam logic REG_LOOP   = 1'b0;
  localparam logic REG_SETTLE = 1'b1;

  localparam logic [TIME_W-1:0]   APPEND_DUR_MS = 16'd3000;
  localparam logic [TIME_W-1:0]   LEG_FLOOR_MS  = 16'd50;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET  = 10'd40;

  typedef struct packed {
    logic                loop_en;
    logic [SETTLE_W-1:0] settle_ms;
  } kms_cfg_t;

endpackage

FILE: rtl/kms_stream_if.sv
// ----------------------------------------------------------------------------
// Keyframe motion sequencer channels
// Command request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface kms_cmd_if import kms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [NOW_W-1:0]         now_ms;
  logic                     estop;
  logic                     any_running;
  logic [SLOT_W-1:0]        slot;
  logic signed [POS_W-1:0]  pos_a;
  logic signed [POS_W-1:0]  pos_b;
  logic [TIME_W-1:0]        duration_ms;
  logic [TIME_W-1:0]        hold_ms;

  modport source (output valid, func, now_ms, estop, any_running, slot, pos_a, pos_b,
                  duration_ms, hold_ms, input ready);
  modport sink (input valid, func, now_ms, estop, any_running, slot, pos_a, pos_b,
                duration_ms, hold_ms, output ready);
endinterface

interface kms_res_if import kms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [MODE_W-1:0]        run_state;
  logic [SLOT_W-1:0]        cur_index;
  logic [COUNT_W-1:0]       frame_count;
  logic                     leg_start;
  logic                     stop_all;
  logic signed [POS_W-1:0]  target_a;
  logic signed [POS_W-1:0]  target_b;
  logic [TIME_W-1:0]        leg_min_ms;

  modport source (output valid, status, run_state, cur_index, frame_count, leg_start,
                  stop_all, target_a, target_b, leg_min_ms, input ready);
  modport sink (input valid, status, run_state, cur_index, frame_count, leg_start,
                stop_all, target_a, target_b, leg_min_ms, output ready);
endinterface

FILE: rtl/keyframe_motion_sequencer.sv
// ----------------------------------------------------------------------------
// Keyframe motion sequencer
// Keyframe table with editing commands and timed playback of motion legs.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken, worked on, and its single result
// is written to an output register once that register is free, and the next
// request is taken as soon as the result is written, even if it still waits.
// Leg starts and ticks that read a hold time pass through extra states for the
// keyframe RAM's registered read. Insert and remove move the table one entry
// per cycle through the RAM's read and write ports. The table needs no
// clearing after reset; entries never written read back as undefined data.
module keyframe_motion_sequencer import kms_pkg::*; #(
  parameter int unsigned MAX_FRAMES = KMS_MAX_FRAMES,
  parameter int unsigned AXES       = KMS_AXES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kms_cmd_if.sink           cmd_i,
  kms_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned MEM_W = AXES * POS_W + 2 * TIME_W;

  kms_cfg_t         cfg;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [MEM_W-1:0] mem_rdata;

  kms_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  kms_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_FRAMES)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  kms_seq_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .AXES       (AXES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd         (cmd_i),
    .res         (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

FILE: rtl/kms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/kms_apb_regs.sv
// ----------------------------------------------------------------------------
// Keyframe motion sequencer configuration registers
// APB-style register file for loop enable and settle time.
// ----------------------------------------------------------------------------
module kms_apb_regs import kms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o,
  output kms_cfg_t          cfg_o
);

  logic                loop_en_q;
  logic [SETTLE_W-1:0] settle_q;
  logic                wr_en;
  logic                reg_idx;

  assign reg_idx  = paddr_i[2];
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q <= 1'b0;
      settle_q  <= SETTLE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOOP:   loop_en_q <= pwdata_i[0];
        REG_SETTLE: settle_q  <= pwdata_i[SETTLE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOOP:   prdata_o = APB_DW'(loop_en_q);
      REG_SETTLE: prdata_o = APB_DW'(settle_q);
      default:    prdata_o = '0;
    endcase
  end

  assign cfg_o.loop_en   = loop_en_q;
  assign cfg_o.settle_ms = settle_q;

endmodule

FILE: rtl/kms_seq_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe motion sequencer controller
// Command decode, table shifting through the keyframe RAM, playback states.
// ----------------------------------------------------------------------------
`include "keyframe_motion_sequencer_macros.svh"

module kms_seq_ctrl import kms_pkg::*; #(
  parameter int unsigned MAX_FRAMES = KMS_MAX_FRAMES,
  parameter int unsigned AXES       = KMS_AXES,
  localparam int unsigned IDX_W = $clog2(MAX_FRAMES),
  localparam int unsigned MEM_W = AXES * POS_W + 2 * TIME_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kms_cfg_t         cfg_i,
  kms_cmd_if.sink          cmd,
  kms_res_if.source        res,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output logic [MEM_W-1:0] mem_wdata_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  logic [MEM_W-1:0] mem_rdata_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned TGT_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int unsigned CNTO_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned DUR_LO  = AXES * POS_W;
  localparam int unsigned HOLD_LO = AXES * POS_W + TIME_W;
  localparam int unsigned B_SEL   = (AXES > 1) ? 1 : 0;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SHIFT, S_START, S_LEG_RD, S_LEG_DAT, S_HOLD_RD, S_HOLD_DAT, S_DONE
  } state_e;

  state_e state_q;

  // Latched request.
  logic [FUNC_W-1:0]  func_q;
  logic [NOW_W-1:0]   now_q;
  logic               estop_q;
  logic               busy_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [POS_W-1:0]   pa_q;
  logic [POS_W-1:0]   pb_q;
  logic [TIME_W-1:0]  dur_q;
  logic [TIME_W-1:0]  hold_q;

  // Playback state.
  logic [MODE_W-1:0]  mode_q;
  logic [IDX_W-1:0]   leg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               one_shot_q;
  logic [NOW_W-1:0]   started_q;
  logic [NOW_W-1:0]   deadline_q;

  // Work registers.
  logic [TGT_W-1:0]   tgt_q;
  logic               report_q;
  logic [TGT_W-1:0]   rd_ptr_q;
  logic [TGT_W-1:0]   rd_left_q;
  logic               wr_pend_q;
  logic [TGT_W-1:0]   wr_addr_q;
  logic [TGT_W-1:0]   ins_at_q;
  logic               shift_up_q;

  // Result being built.
  logic [STATUS_W-1:0] st_q;
  logic                stop_q;
  logic                leg_start_q;
  logic [POS_W-1:0]    ta_q;
  logic [POS_W-1:0]    tb_q;
  logic [TIME_W-1:0]   min_q;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [MODE_W-1:0]   out_mode_q;
  logic [SLOT_W-1:0]   out_idx_q;
  logic [COUNT_W-1:0]  out_cnt_q;
  logic                out_leg_q;
  logic                out_stop_q;
  logic [POS_W-1:0]    out_ta_q;
  logic [POS_W-1:0]    out_tb_q;
  logic [TIME_W-1:0]   out_min_q;

  logic [TGT_W-1:0]  cnt_ext;
  logic [TGT_W-1:0]  leg_ext;
  logic [TGT_W-1:0]  slot_ext;
  logic [TGT_W-1:0]  leg_next;
  logic [CNTO_W-1:0] cnt_wide;
  logic [CNT_W-1:0]  cnt_dec;
  logic              full;
  logic              active;
  logic              settling;
  logic [NOW_W-1:0]  hold_diff;
  logic              hold_due;
  logic              adv_next;
  logic              adv_wrap;
  logic              shift_done;
  logic [MODE_W-1:0] play_mode;
  logic [MEM_W-1:0]  new_frame;
  logic [TIME_W-1:0] rd_dur;
  logic [TIME_W-1:0] rd_hold;

  assign cnt_ext  = TGT_W'(cnt_q);
  assign leg_ext  = TGT_W'(leg_q);
  assign slot_ext = TGT_W'(slot_q);
  assign leg_next = leg_ext + TGT_W'(1);
  assign cnt_wide = CNTO_W'(cnt_q);
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign full     = (cnt_q >= CNT_W'(MAX_FRAMES));
  assign active   = (mode_q == MODE_MOVING) || (mode_q == MODE_HOLDING);
  assign settling = ((now_q - started_q) < NOW_W'(cfg_i.settle_ms));
  assign hold_diff = now_q - deadline_q;
  assign hold_due = ~hold_diff[NOW_W-1];
  assign adv_next = (leg_next < cnt_ext);
  assign adv_wrap = cfg_i.loop_en && (cnt_q != '0);
  assign shift_done = (rd_left_q == '0) && !wr_pend_q;
  // Restart behaves as a stop first, so its play sees an idle sequencer.
  assign play_mode = (func_q == FN_RESTART) ? MODE_IDLE : mode_q;
  assign rd_dur   = mem_rdata_i[DUR_LO +: TIME_W];
  assign rd_hold  = mem_rdata_i[HOLD_LO +: TIME_W];

  always_comb begin
    new_frame = '0;
    for (int a = 0; a < AXES; a++) begin
      if (a == 0) begin
        new_frame[a*POS_W +: POS_W] = pa_q;
      end else if (a == 1) begin
        new_frame[a*POS_W +: POS_W] = pb_q;
      end
    end
    if (func_q == FN_APPEND) begin
      new_frame[DUR_LO +: TIME_W] = APPEND_DUR_MS;
    end else begin
      new_frame[DUR_LO +: TIME_W]  = dur_q;
      new_frame[HOLD_LO +: TIME_W] = hold_q;
    end
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_ext[IDX_W-1:0];
    mem_wdata_o = new_frame;
    case (state_q)
      S_EXEC: begin
        if (func_q == FN_APPEND && !full) begin
          mem_we_o = 1'b1;
        end else if (func_q == FN_REPLACE && slot_ext < cnt_ext) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_ext[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        if (wr_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_addr_q[IDX_W-1:0];
          mem_wdata_o = mem_rdata_i;
        end else if (rd_left_q == '0 && shift_up_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ins_at_q[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign mem_raddr_o = (state_q == S_SHIFT) ? rd_ptr_q[IDX_W-1:0] : tgt_q[IDX_W-1:0];
  assign cmd.ready   = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      leg_q       <= '0;
      cnt_q       <= '0;
      one_shot_q  <= 1'b0;
      started_q   <= '0;
      deadline_q  <= '0;
      wr_pend_q   <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && res.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd.valid) begin
            func_q      <= cmd.func;
            now_q       <= cmd.now_ms;
            estop_q     <= cmd.estop;
            busy_q      <= cmd.any_running;
            slot_q      <= cmd.slot;
            pa_q        <= cmd.pos_a;
            pb_q        <= cmd.pos_b;
            dur_q       <= cmd.duration_ms;
            hold_q      <= cmd.hold_ms;
            st_q        <= ST_OK;
            stop_q      <= 1'b0;
            leg_start_q <= 1'b0;
            ta_q        <= '0;
            tb_q        <= '0;
            min_q       <= '0;
            state_q     <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          case (func_q)
            FN_TICK: begin
              if (mode_q == MODE_MOVING) begin
                if (estop_q) begin
                  mode_q <= MODE_PAUSED;
                end else if (!settling && !busy_q) begin
                  if (one_shot_q) begin
                    one_shot_q <= 1'b0;
                    mode_q     <= MODE_IDLE;
                  end else begin
                    tgt_q   <= leg_ext;
                    state_q <= S_HOLD_RD;
                  end
                end
              end else if (mode_q == MODE_HOLDING) begin
                if (estop_q) begin
                  mode_q <= MODE_PAUSED;
                end else if (hold_due) begin
                  report_q <= 1'b0;
                  if (adv_next) begin
                    tgt_q   <= leg_next;
                    state_q <= S_START;
                  end else if (adv_wrap) begin
                    tgt_q   <= '0;
                    state_q <= S_START;
                  end else begin
                    mode_q <= MODE_IDLE;
                  end
                end
              end
            end
            FN_APPEND: begin
              if (full) begin
                st_q <= ST_FULL;
              end else begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
            end
            FN_INSERT: begin
              if (full) begin
                st_q <= ST_FULL;
              end else begin
                ins_at_q   <= (slot_ext > cnt_ext) ? cnt_ext : slot_ext;
                rd_ptr_q   <= cnt_ext - TGT_W'(1);
                rd_left_q  <= (slot_ext > cnt_ext) ? '0 : cnt_ext - slot_ext;
                shift_up_q <= 1'b1;
                wr_pend_q  <= 1'b0;
                state_q    <= S_SHIFT;
              end
            end
            FN_REPLACE: begin
              if (slot_ext >= cnt_ext) begin
                st_q <= ST_RANGE;
              end
            end
            FN_REMOVE: begin
              if (slot_ext >= cnt_ext) begin
                st_q <= ST_RANGE;
              end else begin
                rd_ptr_q   <= slot_ext + TGT_W'(1);
                rd_left_q  <= cnt_ext - slot_ext - TGT_W'(1);
                shift_up_q <= 1'b0;
                wr_pend_q  <= 1'b0;
                state_q    <= S_SHIFT;
              end
            end
            FN_REMOVE_LAST: begin
              if (cnt_q != '0) begin
                rd_left_q  <= '0;
                shift_up_q <= 1'b0;
                wr_pend_q  <= 1'b0;
                state_q    <= S_SHIFT;
              end
            end
            FN_CLEAR: begin
              stop_q     <= 1'b1;
              mode_q     <= MODE_IDLE;
              leg_q      <= '0;
              one_shot_q <= 1'b0;
              cnt_q      <= '0;
            end
            FN_STOP: begin
              stop_q     <= 1'b1;
              mode_q     <= MODE_IDLE;
              leg_q      <= '0;
              one_shot_q <= 1'b0;
            end
            FN_PLAY, FN_PAUSE, FN_TOGGLE, FN_RESTART: begin
              if ((func_q == FN_PAUSE || func_q == FN_TOGGLE) && active) begin
                stop_q <= 1'b1;
                mode_q <= MODE_PAUSED;
              end else if (func_q != FN_PAUSE) begin
                if (func_q == FN_RESTART) begin
                  stop_q <= 1'b1;
                  mode_q <= MODE_IDLE;
                end
                if (cnt_q == '0) begin
                  st_q <= ST_EMPTY;
                  if (func_q == FN_RESTART) begin
                    leg_q      <= '0;
                    one_shot_q <= 1'b0;
                  end
                end else if (play_mode == MODE_PAUSED) begin
                  // Resume re-issues the interrupted leg; a refusal is not reported.
                  one_shot_q <= 1'b0;
                  tgt_q      <= leg_ext;
                  report_q   <= 1'b0;
                  state_q    <= S_START;
                end else if (play_mode != MODE_MOVING) begin
                  leg_q      <= '0;
                  one_shot_q <= 1'b0;
                  tgt_q      <= '0;
                  report_q   <= 1'b1;
                  state_q    <= S_START;
                end
              end
            end
            FN_GOTO: begin
              tgt_q    <= slot_ext;
              report_q <= 1'b1;
              state_q  <= S_START;
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          if (rd_left_q != '0) begin
            wr_pend_q <= 1'b1;
            wr_addr_q <= shift_up_q ? rd_ptr_q + TGT_W'(1) : rd_ptr_q - TGT_W'(1);
            rd_ptr_q  <= shift_up_q ? rd_ptr_q - TGT_W'(1) : rd_ptr_q + TGT_W'(1);
            rd_left_q <= rd_left_q - TGT_W'(1);
          end else begin
            wr_pend_q <= 1'b0;
          end
          if (shift_done) begin
            state_q <= S_DONE;
            if (shift_up_q) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end else begin
              cnt_q <= cnt_dec;
              if (leg_ext >= TGT_W'(cnt_dec)) begin
                leg_q <= (cnt_dec == '0) ? '0 : IDX_W'(cnt_dec - CNT_W'(1));
              end
            end
          end
        end
        S_START: begin
          if (tgt_q >= cnt_ext) begin
            if (report_q) begin
              st_q <= ST_RANGE;
            end
            if (func_q == FN_GOTO) begin
              one_shot_q <= 1'b0;
            end
            state_q <= S_DONE;
          end else if (estop_q) begin
            if (report_q) begin
              st_q <= ST_ESTOP;
            end
            if (func_q == FN_GOTO) begin
              one_shot_q <= 1'b0;
            end
            state_q <= S_DONE;
          end else begin
            state_q <= S_LEG_RD;
          end
        end
        S_LEG_RD: begin
          state_q <= S_LEG_DAT;
        end
        S_LEG_DAT: begin
          leg_start_q <= 1'b1;
          ta_q        <= mem_rdata_i[POS_W-1:0];
          tb_q        <= (AXES > 1) ? mem_rdata_i[B_SEL*POS_W +: POS_W] : '0;
          min_q       <= (rd_dur < LEG_FLOOR_MS) ? LEG_FLOOR_MS : rd_dur;
          leg_q       <= tgt_q[IDX_W-1:0];
          started_q   <= now_q;
          mode_q      <= MODE_MOVING;
          if (func_q == FN_GOTO) begin
            one_shot_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_HOLD_RD: begin
          state_q <= S_HOLD_DAT;
        end
        S_HOLD_DAT: begin
          state_q <= S_DONE;
          if (rd_hold != '0) begin
            deadline_q <= now_q + NOW_W'(rd_hold);
            mode_q     <= MODE_HOLDING;
          end else begin
            report_q <= 1'b0;
            if (adv_next) begin
              tgt_q   <= leg_next;
              state_q <= S_START;
            end else if (adv_wrap) begin
              tgt_q   <= '0;
              state_q <= S_START;
            end else begin
              mode_q <= MODE_IDLE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || res.ready) begin
            out_valid_q <= 1'b1;
            out_st_q    <= st_q;
            out_mode_q  <= mode_q;
            out_idx_q   <= leg_ext[SLOT_W-1:0];
            out_cnt_q   <= cnt_wide[COUNT_W-1:0];
            out_leg_q   <= leg_start_q;
            out_stop_q  <= stop_q;
            out_ta_q    <= ta_q;
            out_tb_q    <= tb_q;
            out_min_q   <= min_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = out_valid_q;
  assign res.status      = out_st_q;
  assign res.run_state   = out_mode_q;
  assign res.cur_index   = out_idx_q;
  assign res.frame_count = out_cnt_q;
  assign res.leg_start   = out_leg_q;
  assign res.stop_all    = out_stop_q;
  assign res.target_a    = out_ta_q;
  assign res.target_b    = out_tb_q;
  assign res.leg_min_ms  = out_min_q;

  `KMS_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_FRAMES), "count above capacity")
  `KMS_ASSERT(a_leg_in_range, clk_i, rst_ni, (leg_ext < cnt_ext) || (leg_q == '0), "index past table")
  `KMS_ASSERT(a_leg_moving, clk_i, rst_ni, (out_valid_q && out_leg_q) |-> (out_mode_q == MODE_MOVING), "leg start while not moving")
  `KMS_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without completion")
  `KMS_ASSERT_NEVER(a_shift_no_req, clk_i, rst_ni, (state_q == S_SHIFT) && cmd.ready, "request taken during shift")

endmodule

FILE: dv/keyframe_motion_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Keyframe motion sequencer testbench
// Drives editing, playback and tick requests through the command channel,
// predicts every result with a behavioral model of the sequencer, and compares
// each result field by field. It changes the loop and settle registers
// between phases, and applies random idling and a long result stall.
// ----------------------------------------------------------------------------
module keyframe_motion_sequencer_tb;
  import kms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [NOW_W-1:0]        now_ms;
    logic                    estop;
    logic                    any_running;
    logic [SLOT_W-1:0]       slot;
    logic [POS_W-1:0]        pos_a;
    logic [POS_W-1:0]        pos_b;
    logic [TIME_W-1:0]       duration_ms;
    logic [TIME_W-1:0]       hold_ms;
  } seq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MODE_W-1:0]   run_state;
    logic [SLOT_W-1:0]   cur_index;
    logic [COUNT_W-1:0]  frame_count;
    logic                leg_start;
    logic                stop_all;
    logic [POS_W-1:0]    target_a;
    logic [POS_W-1:0]    target_b;
    logic [TIME_W-1:0]   leg_min_ms;
  } seq_res_t;

  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd13;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;
  localparam logic [APB_AW-1:0] ADDR_LOOP    = {REG_LOOP, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SETTLE  = {REG_SETTLE, 2'b00};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  kms_cmd_if cmd_bus ();
  kms_res_if res_bus ();

  keyframe_motion_sequencer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sequencer shadow state.
  logic [POS_W-1:0]    kf_pos_a [KMS_MAX_FRAMES];
  logic [POS_W-1:0]    kf_pos_b [KMS_MAX_FRAMES];
  logic [TIME_W-1:0]   kf_dur [KMS_MAX_FRAMES];
  logic [TIME_W-1:0]   kf_hold [KMS_MAX_FRAMES];
  logic [MODE_W-1:0]   sh_mode = MODE_IDLE;
  int unsigned         sh_index = 0;
  int unsigned         sh_count = 0;
  logic                sh_one_shot = 1'b0;
  logic [NOW_W-1:0]    sh_leg_t0 = '0;
  logic [NOW_W-1:0]    sh_deadline = '0;
  logic                sh_loop = 1'b0;
  logic [SETTLE_W-1:0] sh_settle = SETTLE_RESET;
  logic [NOW_W-1:0]    step_now;
  logic                step_estop;
  seq_res_t            step_out;

  seq_req_t req_q[$];
  seq_res_t expected_q[$];
  seq_req_t cur_req;
  int       sent_cnt = 0;
  int       rcvd_cnt = 0;
  int       mismatches = 0;
  int       legs_seen = 0;
  bit       rx_hold_req = 1'b0;
  int       rx_hold_cnt = 0;
  logic [NOW_W-1:0] clock_ms = 32'd1000;

  function automatic logic [STATUS_W-1:0] launch_leg(int unsigned tgt);
    if (tgt >= sh_count) return ST_RANGE;
    if (step_estop) return ST_ESTOP;
    step_out.leg_start = 1'b1;
    step_out.target_a = kf_pos_a[tgt];
    step_out.target_b = kf_pos_b[tgt];
    step_out.leg_min_ms = (kf_dur[tgt] < LEG_FLOOR_MS) ? LEG_FLOOR_MS : kf_dur[tgt];
    sh_index = tgt;
    sh_leg_t0 = step_now;
    sh_mode = MODE_MOVING;
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] start_playback();
    if (sh_count == 0) return ST_EMPTY;
    if (sh_mode == MODE_MOVING) return ST_OK;
    sh_one_shot = 1'b0;
    if (sh_mode == MODE_PAUSED) begin
      void'(launch_leg(sh_index));
      return ST_OK;
    end
    sh_index = 0;
    return launch_leg(0);
  endfunction

  function automatic void halt_all();
    step_out.stop_all = 1'b1;
    sh_mode = MODE_IDLE;
    sh_index = 0;
    sh_one_shot = 1'b0;
  endfunction

  function automatic void next_leg();
    if (sh_index + 1 < sh_count) void'(launch_leg(sh_index + 1));
    else if (sh_loop && sh_count > 0) void'(launch_leg(0));
    else sh_mode = MODE_IDLE;
  endfunction

  function automatic void tick_playback(logic busy);
    logic [NOW_W-1:0] age;
    logic [NOW_W-1:0] late;
    age = step_now - sh_leg_t0;
    late = step_now - sh_deadline;
    if (sh_mode == MODE_MOVING) begin
      if (step_estop) sh_mode = MODE_PAUSED;
      else if (age < NOW_W'(sh_settle) || busy) return;
      else if (sh_one_shot) begin
        sh_one_shot = 1'b0;
        sh_mode = MODE_IDLE;
      end else if (kf_hold[sh_index] != 0) begin
        sh_deadline = step_now + NOW_W'(kf_hold[sh_index]);
        sh_mode = MODE_HOLDING;
      end else begin
        next_leg();
      end
    end else if (sh_mode == MODE_HOLDING) begin
      if (step_estop) sh_mode = MODE_PAUSED;
      else if (late < 32'h8000_0000) next_leg();
    end
  endfunction

  function automatic void store_frame(int unsigned at, seq_req_t r, logic [TIME_W-1:0] dur,
                                      logic [TIME_W-1:0] hold);
    kf_pos_a[at] = r.pos_a;
    kf_pos_b[at] = r.pos_b;
    kf_dur[at] = dur;
    kf_hold[at] = hold;
  endfunction

  function automatic logic [STATUS_W-1:0] delete_frame(int unsigned at);
    if (at >= sh_count) return ST_RANGE;
    for (int unsigned i = at; i + 1 < sh_count; i++) begin
      kf_pos_a[i] = kf_pos_a[i+1];
      kf_pos_b[i] = kf_pos_b[i+1];
      kf_dur[i] = kf_dur[i+1];
      kf_hold[i] = kf_hold[i+1];
    end
    sh_count--;
    if (sh_index >= sh_count) sh_index = (sh_count != 0) ? sh_count - 1 : 0;
    return ST_OK;
  endfunction

  function automatic seq_res_t sequencer_step(seq_req_t r);
    int unsigned at;
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    step_now = r.now_ms;
    step_estop = r.estop;
    step_out = '0;
    case (r.func)
      FN_TICK: tick_playback(r.any_running);
      FN_APPEND: begin
        if (sh_count >= KMS_MAX_FRAMES) st = ST_FULL;
        else begin
          store_frame(sh_count, r, APPEND_DUR_MS, '0);
          sh_count++;
        end
      end
      FN_INSERT: begin
        if (sh_count >= KMS_MAX_FRAMES) st = ST_FULL;
        else begin
          at = (r.slot > sh_count) ? sh_count : r.slot;
          for (int unsigned i = sh_count; i > at; i--) begin
            kf_pos_a[i] = kf_pos_a[i-1];
            kf_pos_b[i] = kf_pos_b[i-1];
            kf_dur[i] = kf_dur[i-1];
            kf_hold[i] = kf_hold[i-1];
          end
          store_frame(at, r, r.duration_ms, r.hold_ms);
          sh_count++;
        end
      end
      FN_REPLACE: begin
        if (r.slot >= sh_count) st = ST_RANGE;
        else store_frame(r.slot, r, r.duration_ms, r.hold_ms);
      end
      FN_REMOVE: st = delete_frame(r.slot);
      FN_REMOVE_LAST: if (sh_count > 0) void'(delete_frame(sh_count - 1));
      FN_CLEAR: begin
        halt_all();
        sh_count = 0;
      end
      FN_PLAY: st = start_playback();
      FN_PAUSE, FN_TOGGLE: begin
        if (sh_mode == MODE_MOVING || sh_mode == MODE_HOLDING) begin
          step_out.stop_all = 1'b1;
          sh_mode = MODE_PAUSED;
        end else if (r.func == FN_TOGGLE) begin
          st = start_playback();
        end
      end
      FN_STOP: halt_all();
      FN_RESTART: begin
        halt_all();
        st = start_playback();
      end
      FN_GOTO: begin
        sh_one_shot = 1'b1;
        st = launch_leg(r.slot);
        if (st != ST_OK) sh_one_shot = 1'b0;
      end
      default: ;
    endcase
    step_out.status = st;
    step_out.run_state = sh_mode;
    step_out.cur_index = SLOT_W'(sh_index);
    step_out.frame_count = COUNT_W'(sh_count);
    return step_out;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        expected_q.push_back(sequencer_step(cur_req));
        sent_cnt++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (req_q.size() > 0 &&
            ((sent_cnt >= 150 && sent_cnt < 230) || $urandom_range(99) >= 35)) begin
          cur_req = req_q.pop_front();
          cmd_bus.valid       <= 1'b1;
          cmd_bus.func        <= cur_req.func;
          cmd_bus.now_ms      <= cur_req.now_ms;
          cmd_bus.estop       <= cur_req.estop;
          cmd_bus.any_running <= cur_req.any_running;
          cmd_bus.slot        <= cur_req.slot;
          cmd_bus.pos_a       <= cur_req.pos_a;
          cmd_bus.pos_b       <= cur_req.pos_b;
          cmd_bus.duration_ms <= cur_req.duration_ms;
          cmd_bus.hold_ms     <= cur_req.hold_ms;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Long result stall, counted in cycles.
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_cnt = 300;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
    end
  end

  // Result monitor and checker.
  always @(posedge clk_i) begin
    seq_res_t got;
    seq_res_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got = '{res_bus.status, res_bus.run_state, res_bus.cur_index, res_bus.frame_count,
                res_bus.leg_start, res_bus.stop_all, res_bus.target_a, res_bus.target_b,
                res_bus.leg_min_ms};
        rcvd_cnt++;
        if (got.leg_start === 1'b1) legs_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("[%0t] result with nothing expected", $realtime);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.run_state !== want.run_state ||
              got.cur_index !== want.cur_index || got.frame_count !== want.frame_count ||
              got.leg_start !== want.leg_start || got.stop_all !== want.stop_all ||
              got.target_a !== want.target_a || got.target_b !== want.target_b ||
              got.leg_min_ms !== want.leg_min_ms) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, rcvd_cnt);
              $display("  expected st=%0d mode=%0d idx=%0d cnt=%0d leg=%0b stop=%0b a=%h b=%h min=%0d",
                       want.status, want.run_state, want.cur_index, want.frame_count,
                       want.leg_start, want.stop_all, want.target_a, want.target_b,
                       want.leg_min_ms);
              $display("  actual   st=%0d mode=%0d idx=%0d cnt=%0d leg=%0b stop=%0b a=%h b=%h min=%0d",
                       got.status, got.run_state, got.cur_index, got.frame_count,
                       got.leg_start, got.stop_all, got.target_a, got.target_b,
                       got.leg_min_ms);
            end
          end
        end
      end
      if (rx_hold_req || rx_hold_cnt > 0) begin
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= (rcvd_cnt >= 150 && rcvd_cnt < 230) || $urandom_range(99) >= 35;
      end
    end
  end

  task automatic add_req(logic [FUNC_W-1:0] fn, logic [SLOT_W-1:0] slot,
                         logic [POS_W-1:0] pa, logic [POS_W-1:0] pb,
                         logic [TIME_W-1:0] dur, logic [TIME_W-1:0] hold,
                         logic estop, logic busy);
    req_q.push_back('{fn, clock_ms, estop, busy, slot, pa, pb, dur, hold});
  endtask

  task automatic add_tick(int unsigned adv, logic busy, logic estop);
    clock_ms += adv;
    add_req(FN_TICK, SLOT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
            TIME_W'($urandom), TIME_W'($urandom), estop, busy);
  endtask

  function automatic logic [TIME_W-1:0] rand_hold();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return '0;
    if (r < 9) return TIME_W'($urandom_range(1, 150));
    return TIME_W'($urandom);
  endfunction

  task automatic add_edit(logic [FUNC_W-1:0] fn);
    add_req(fn, SLOT_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(7)),
            POS_W'($urandom), POS_W'($urandom),
            TIME_W'($urandom_range(1) ? $urandom : $urandom_range(120)), rand_hold(),
            $urandom_range(19) == 0, $urandom);
  endtask

  task automatic add_random_phase(int n);
    int k;
    int r;
    int len;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 22) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0, 1, 2: add_edit(FN_APPEND);
            3, 4, 5: add_edit(FN_INSERT);
            6:       add_edit(FN_REPLACE);
            7:       add_edit(FN_REMOVE);
            default: add_edit(FN_REMOVE_LAST);
          endcase
        end
        k += len;
      end else if (r < 32) begin
        case ($urandom_range(4))
          0, 1: add_edit(FN_PLAY);
          2:    add_edit(FN_GOTO);
          3:    add_edit(FN_RESTART);
          default: add_edit(FN_TOGGLE);
        endcase
        k++;
      end else if (r < 36) begin
        case ($urandom_range(5))
          0, 1: add_edit(FN_PAUSE);
          2:    add_edit(FN_STOP);
          3:    add_edit(FN_CLEAR);
          default: add_edit(FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)));
        endcase
        k++;
      end else begin
        len = $urandom_range(3, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(49) == 0) clock_ms = $urandom;
          add_tick($urandom_range(60), $urandom_range(9) < 3, $urandom_range(39) == 0);
        end
        k += len;
      end
    end
  endtask

  task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LOOP) sh_loop = data[0];
    else sh_settle = data[SETTLE_W-1:0];
  endtask

  task automatic drain_and_config(logic loop_en, logic [SETTLE_W-1:0] settle);
    do @(posedge clk_i);
    while (req_q.size() != 0 || cmd_bus.valid || expected_q.size() != 0);
    repeat (50) @(posedge clk_i);
    reg_write(ADDR_LOOP, APB_DW'(loop_en));
    reg_write(ADDR_SETTLE, APB_DW'(settle));
  endtask

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.func = FN_TICK;
    cmd_bus.now_ms = '0;
    cmd_bus.estop = 1'b0;
    cmd_bus.any_running = 1'b0;
    cmd_bus.slot = '0;
    cmd_bus.pos_a = '0;
    cmd_bus.pos_b = '0;
    cmd_bus.duration_ms = '0;
    cmd_bus.hold_ms = '0;
    res_bus.ready = 1'b0;
    for (int i = 0; i < KMS_MAX_FRAMES; i++) begin
      kf_pos_a[i] = '0;
      kf_pos_b[i] = '0;
      kf_dur[i] = '0;
      kf_hold[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on reset register values.
    add_req(FN_PLAY, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_PAUSE, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_REMOVE_LAST, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_REMOVE, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_REPLACE, 5'd31, 0, 0, 0, 0, 0, 0);
    add_req(FN_GOTO, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_UNUSED_HI, 5'd31, '1, '1, '1, '1, 1, 1);
    add_req(FN_APPEND, 0, 24'h800000, 24'h7FFFFF, 0, 0, 0, 0);
    add_req(FN_INSERT, 5'd31, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'd20, 0, 0);
    add_req(FN_INSERT, 5'd0, 24'h000001, 24'hFFFFFF, 16'd0, 16'hFFFF, 0, 0);
    add_req(FN_REPLACE, 5'd2, 24'h123456, 24'hABCDEF, 16'd49, 16'd0, 0, 0);
    add_req(FN_GOTO, 5'd3, 0, 0, 0, 0, 1, 0);
    add_req(FN_GOTO, 5'd1, 0, 0, 0, 0, 1, 0);
    add_req(FN_PLAY, 0, 0, 0, 0, 0, 0, 0);
    add_tick(10, 0, 0);
    add_tick(40, 1, 0);
    add_tick(5, 0, 1);
    add_req(FN_PLAY, 0, 0, 0, 0, 0, 1, 0);
    add_tick(50, 0, 0);
    add_req(FN_TOGGLE, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_TOGGLE, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_STOP, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_RESTART, 0, 0, 0, 0, 0, 0, 0);
    add_req(FN_REMOVE, 5'd0, 0, 0, 0, 0, 0, 0);
    add_req(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0);

    // Loop on, no settle guard; the result side stalls long at the start.
    drain_and_config(1'b1, '0);
    rx_hold_req = 1'b1;
    add_random_phase(90);

    // Fill the table past full, longest settle guard, no loop.
    drain_and_config(1'b0, '1);
    for (int i = 0; i < 34; i++) add_edit(i[0] ? FN_APPEND : FN_INSERT);
    add_random_phase(60);

    // Loop with a short guard while the millisecond clock wraps.
    drain_and_config(1'b1, 10'd5);
    clock_ms = 32'hFFFF_FE00;
    add_req(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_random_phase(95);

    drain_and_config(1'b0, '0);
    add_random_phase(95);

    do @(posedge clk_i);
    while (req_q.size() != 0 || cmd_bus.valid || expected_q.size() != 0);
    repeat (60) @(posedge clk_i);
    mismatches += expected_q.size();
    $display("Checked %0d results for %0d requests, %0d of them leg starts.",
             rcvd_cnt, sent_cnt, legs_seen);
    $display("Loop on and off, settle from 0 to 1023, a full table and a clock wrap.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout after %0d results", rcvd_cnt);
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: keyframe_motion_sequencer.f
+incdir+rtl
rtl/kms_pkg.sv
rtl/kms_stream_if.sv
rtl/kms_ram.sv
rtl/kms_apb_regs.sv
rtl/kms_seq_ctrl.sv
rtl/keyframe_motion_sequencer.sv
dv/keyframe_motion_sequencer_tb.sv
